FILE: hw/rtl/layer_alpha_compositor_unit_defines.svh
// Assertion macros for the compositor RTL (used by the sequencer)
`ifndef LAYER_ALPHA_COMPOSITOR_UNIT_DEFINES_SVH
`define LAYER_ALPHA_COMPOSITOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lac_pkg.sv
// Shared types, constants and helpers for the layer alpha compositor
package lac_pkg;

  localparam int TILE_SIZE     = 16;
  localparam int MAX_DIMENSION = 4096;
  localparam int COORD_W       = 12;
  localparam int PIX_W         = 32;
  localparam int CH_W          = 8;
  localparam int PROD_W        = 2 * CH_W;

  // coordinate / TILE_SIZE as a multiply by a rounded-up reciprocal
  localparam int DIV_SHIFT = 2 * $clog2(MAX_DIMENSION);
  localparam int RECIP_W   = DIV_SHIFT;
  localparam longint TILE_RECIP_L = ((64'd1 << DIV_SHIFT) + TILE_SIZE - 1) / TILE_SIZE;
  localparam logic [RECIP_W-1:0] TILE_RECIP = RECIP_W'(TILE_RECIP_L);
  localparam int QPROD_W = COORD_W + RECIP_W;

  localparam logic [PIX_W-1:0] CHECKER_LIGHT_RST = 32'hFF2A2A2A;
  localparam logic [PIX_W-1:0] CHECKER_DARK_RST  = 32'hFF222222;
  localparam logic [CH_W-1:0]  ALPHA_OPAQUE      = 8'hFF;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic {
    REG_CHECKER_LIGHT = 1'b0,
    REG_CHECKER_DARK  = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_ALPHA = 5'b00100,
    S_BLEND = 5'b01000,
    S_NORM  = 5'b10000
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_en;
    logic alpha_en;
    logic blend_en;
    logic commit;
  } lac_cmd_t;

  typedef struct packed {
    logic last;
    logic out_stall;
  } lac_status_t;

  // floor(p / 255), exact for p <= 255 * 255
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] t;
    t = {1'b0, p} + {{(CH_W + 1){1'b0}}, p[PROD_W-1:CH_W]} + {{PROD_W{1'b0}}, 1'b1};
    return t[PROD_W-1:CH_W];
  endfunction

endpackage

FILE: hw/rtl/layer_alpha_compositor_unit.sv
// Layer alpha compositor: top level joining the sequencer and the datapath
//
// Input stream: one layer pixel per transfer, bottom layer first. in_tuser
// marks the first layer of a pixel (the accumulator is loaded with the
// checkerboard color picked from the tile parity), in_tlast the last one.
// Each layer is blended source-over, alpha scaled by layer opacity.
// Output stream: one composited pixel per run, sent after the last layer.
// Steps per item: tile parity and alpha product, alpha scale, channel
// multiplies, normalize. Due to the accumulator feedback the next item is
// accepted only while idle or in the normalize step; out_tvalid rises when
// the last layer's result is committed from the normalize step.
// A stalled receiver holds the result in the output register; a further
// last layer waits in the normalize step until the register is free.
// Configuration: cfg_index 0 = light tile color, 1 = dark tile color, always
// ready; to be written only while idle, which the block does not enforce.
// Reset (rst_n low, synchronous): colors to defaults, accumulator to zero,
// output empty.
module layer_alpha_compositor_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pixel_x[11:0], pixel_y[23:12], layer_pixel[55:24], layer_opacity[63:56],
  // layer_visible[64], zero pad[71:65]
  input  logic [lac_pkg::IN_TDATA_W-1:0]     in_tdata,
  // first_layer
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_x[11:0], out_y[23:12], composite_pixel[55:24]
  output logic [lac_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [lac_pkg::PIX_W-1:0]          cfg_data
);
  import lac_pkg::*;

  lac_cmd_t    cmd;
  lac_status_t status;

  assign cfg_ready = 1'b1;

  lac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lac_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

FILE: hw/rtl/lac_ctrl.sv
// Sequencer for the compositor: capture, load, alpha, blend, normalize
`include "layer_alpha_compositor_unit_defines.svh"

module lac_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  lac_pkg::lac_status_t status,
  output lac_pkg::lac_cmd_t    cmd
);
  import lac_pkg::*;

  state_t state_r, state_nxt;
  logic   advance;

  // a finishing item may only leave NORM if its result has somewhere to go
  assign advance   = !status.last || !status.out_stall;
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_NORM) && advance);

  always_comb begin
    cmd.capture  = in_tvalid && in_tready;
    cmd.load_en  = (state_r == S_LOAD);
    cmd.alpha_en = (state_r == S_ALPHA);
    cmd.blend_en = (state_r == S_BLEND);
    cmd.commit   = (state_r == S_NORM) && advance;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (cmd.capture) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_ALPHA;
      S_ALPHA: state_nxt = S_BLEND;
      S_BLEND: state_nxt = S_NORM;
      S_NORM: begin
        if (advance) state_nxt = cmd.capture ? S_LOAD : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LAC_ASSERT_NEXT(a_capture_starts_load, cmd.capture, state_r == S_LOAD, "transfer did not start LOAD")
  `LAC_ASSERT_NOW(a_ready_only_when_free, in_tready, (state_r == S_IDLE) || cmd.commit, "ready while an item is in flight")
  `LAC_ASSERT_NEXT(a_stall_holds_norm, (state_r == S_NORM) && !advance, state_r == S_NORM, "left NORM while output stalled")
  `LAC_ASSERT_NOW(a_onehot_state, 1'b1, $onehot(state_r), "state register not one-hot")

endmodule

FILE: hw/rtl/lac_datapath.sv
// Compositor datapath: input capture, checker select, blend math, output register
module lac_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lac_pkg::lac_cmd_t                  cmd,
  output lac_pkg::lac_status_t               status,
  input  logic [lac_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lac_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [lac_pkg::PIX_W-1:0]          cfg_data
);
  import lac_pkg::*;

  // captured item
  logic [COORD_W-1:0] x_r, y_r;
  logic [PIX_W-1:0]   src_r;
  logic [CH_W-1:0]    opa_r;
  logic               vis_r, first_r, last_r;

  logic [PIX_W-1:0]   light_r, dark_r, acc_r;

  // LOAD stage
  logic [QPROD_W-1:0] qx_prod, qy_prod;
  logic               par_x_r, par_y_r;
  logic [PROD_W-1:0]  sa_prod_r;

  // ALPHA stage
  logic [PIX_W-1:0]   dst_r;
  logic [CH_W-1:0]    sa_r;

  // BLEND stage
  logic [CH_W-1:0]    inv;
  logic [PROD_W-1:0]  sum_r [4];
  logic               skip_r, short_r;

  // NORM stage
  logic [CH_W-1:0]    alpha_out;
  logic [PIX_W-1:0]   result;

  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= CHECKER_LIGHT_RST;
      dark_r  <= CHECKER_DARK_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHECKER_LIGHT: light_r <= cfg_data;
        REG_CHECKER_DARK:  dark_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r     <= in_tdata[11:0];
      y_r     <= in_tdata[23:12];
      src_r   <= in_tdata[55:24];
      opa_r   <= in_tdata[63:56];
      vis_r   <= in_tdata[64];
      first_r <= in_tuser;
      last_r  <= in_tlast;
    end
  end

  assign qx_prod = QPROD_W'(x_r) * QPROD_W'(TILE_RECIP);
  assign qy_prod = QPROD_W'(y_r) * QPROD_W'(TILE_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      par_x_r   <= qx_prod[DIV_SHIFT];
      par_y_r   <= qy_prod[DIV_SHIFT];
      sa_prod_r <= src_r[31:24] * opa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alpha_en) begin
      if (first_r) dst_r <= (par_x_r ^ par_y_r) ? light_r : dark_r;
      else         dst_r <= acc_r;
      sa_r <= div255(sa_prod_r);
    end
  end

  assign inv = ALPHA_OPAQUE - sa_r;

  always_ff @(posedge clk) begin
    if (cmd.blend_en) begin
      sum_r[0] <= src_r[7:0]   * sa_r + dst_r[7:0]   * inv;
      sum_r[1] <= src_r[15:8]  * sa_r + dst_r[15:8]  * inv;
      sum_r[2] <= src_r[23:16] * sa_r + dst_r[23:16] * inv;
      sum_r[3] <= dst_r[31:24] * inv;
      // zero scaled alpha covers zero opacity and zero source alpha
      skip_r   <= !vis_r || (sa_r == '0);
      short_r  <= (sa_r == ALPHA_OPAQUE) && (dst_r[31:24] == '0);
    end
  end

  assign alpha_out = sa_r + div255(sum_r[3]);

  always_comb begin
    if (skip_r)       result = dst_r;
    else if (short_r) result = {ALPHA_OPAQUE, src_r[23:0]};
    else              result = {alpha_out, div255(sum_r[2]), div255(sum_r[1]), div255(sum_r[0])};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.commit) begin
      acc_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && last_r) out_data_r <= {result, y_r, x_r};
  end

  assign out_tvalid       = out_valid_r;
  assign out_tdata        = out_data_r;
  assign status.last      = last_r;
  assign status.out_stall = out_valid_r && !out_tready;

endmodule

FILE: sim/tb.sv
// Testbench for the layer alpha compositor: directed and random layer runs, scoreboard check
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] color;
    logic [7:0]  opacity;
    logic        visible;
    logic        first;
    logic        last;
  } layer_item_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] pixel;
  } composite_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [lac_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [lac_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic                            cfg_index;
  logic [31:0]                     cfg_data;

  // predictor state
  logic [31:0] light_color;
  logic [31:0] dark_color;
  logic [31:0] accum_pixel;
  composite_t  pending_pixels[$];
  composite_t  oldest;

  int unsigned error_count;
  int unsigned layers_sent;
  int unsigned pixels_checked;
  int unsigned color_writes;

  // receiver stall pattern
  int unsigned rx_hold;
  int unsigned rx_stall_max;
  int unsigned rx_run_max;

  layer_alpha_compositor_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] source_over_blend(logic [31:0] dst, logic [31:0] src,
                                                    logic [7:0] opacity);
    int unsigned sa;
    int unsigned inv;
    int unsigned da;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned a;
    sa = (int'(src[31:24]) * int'(opacity)) / 255;
    da = 32'(dst[31:24]);
    if (sa == 0) return dst;
    if (sa == 255 && da == 0) return {8'hFF, src[23:0]};
    inv = 255 - sa;
    r = (int'(src[7:0]) * sa + int'(dst[7:0]) * inv) / 255;
    g = (int'(src[15:8]) * sa + int'(dst[15:8]) * inv) / 255;
    b = (int'(src[23:16]) * sa + int'(dst[23:16]) * inv) / 255;
    a = sa + (da * inv) / 255;
    return {a[7:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  function automatic layer_item_t make_layer(logic [11:0] x, logic [11:0] y, logic [31:0] color,
                                             logic [7:0] opacity, logic visible, logic first,
                                             logic last);
    layer_item_t it;
    it.x = x;
    it.y = y;
    it.color = color;
    it.opacity = opacity;
    it.visible = visible;
    it.first = first;
    it.last = last;
    return it;
  endfunction

  function automatic logic [11:0] rand_coord();
    logic [11:0] c;
    c = 12'($urandom);
    case ($urandom_range(0, 5))
      0: c = 12'd0;
      1: c = 12'd4095;
      2: c[3:0] = 4'hF;
      3: c[3:0] = 4'h0;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] rand_color();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 7))
      0, 1: c[31:24] = 8'h00;
      2, 3: c[31:24] = 8'hFF;
      4: c[23:0] = 24'hFFFFFF;
      5: c[23:0] = 24'h000000;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_opacity();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1, 2, 3: return 8'hFF;
      4: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // one layer transfer; prediction is applied at the accepting edge
  task automatic send_layer(layer_item_t it);
    @(negedge clk);
    in_tdata  = {7'd0, it.visible, it.opacity, it.color, it.y, it.x};
    in_tuser  = it.first;
    in_tlast  = it.last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    layers_sent++;
    if (it.first)
      accum_pixel = (((it.x / lac_pkg::TILE_SIZE) + (it.y / lac_pkg::TILE_SIZE)) % 2 != 0)
                    ? light_color : dark_color;
    if (it.visible && it.opacity != 8'd0 && it.color[31:24] != 8'd0)
      accum_pixel = source_over_blend(accum_pixel, it.color, it.opacity);
    if (it.last) pending_pixels.push_back({it.x, it.y, accum_pixel});
  endtask

  task automatic sender_gap(int unsigned cycles);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // block is idle once every pixel is out and the pipeline has flushed
  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_color(lac_pkg::cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lac_pkg::REG_CHECKER_LIGHT) light_color = value;
    else dark_color = value;
    color_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: out_tdata %h", out_tdata);
        error_count++;
      end else begin
        oldest = pending_pixels.pop_front();
        pixels_checked++;
        if (out_tdata[11:0] !== oldest.x) begin
          $error("out_x mismatch: expected %0d, actual %0d", oldest.x, out_tdata[11:0]);
          error_count++;
        end
        if (out_tdata[23:12] !== oldest.y) begin
          $error("out_y mismatch: expected %0d, actual %0d", oldest.y, out_tdata[23:12]);
          error_count++;
        end
        if (out_tdata[55:24] !== oldest.pixel) begin
          $error("composite_pixel mismatch: expected %h, actual %h", oldest.pixel,
                 out_tdata[55:24]);
          error_count++;
        end
      end
    end
  end

  // receiver stalls on its own schedule, independent of the sender
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold--;
    end else if (out_tready && rx_stall_max != 0) begin
      out_tready = 1'b0;
      rx_hold = $urandom_range(0, rx_stall_max - 1);
    end else begin
      out_tready = 1'b1;
      rx_hold = $urandom_range(0, rx_run_max);
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout with %0d results outstanding", pending_pixels.size());
    $display("layer_alpha_compositor_unit test failed");
    $finish;
  end

  task automatic test_reset_state();
    // accumulator is zero after reset: a run without a start blends over transparent
    send_layer(make_layer(12'd5, 12'd7, 32'hFF123456, 8'hFF, 1'b1, 1'b0, 1'b1));
    send_layer(make_layer(12'd0, 12'd0, 32'hFFFFFFFF, 8'hFF, 1'b0, 1'b1, 1'b1));
    send_layer(make_layer(12'd16, 12'd0, 32'hFFFFFFFF, 8'h00, 1'b1, 1'b1, 1'b1));
    send_layer(make_layer(12'd15, 12'd16, 32'h00ABCDEF, 8'hFF, 1'b1, 1'b1, 1'b1));
    wait_all_results();
  endtask

  task automatic test_directed_blends();
    // alpha 1 at opacity 1 scales to zero
    send_layer(make_layer(12'd31, 12'd31, 32'h01FFFFFF, 8'h01, 1'b1, 1'b1, 1'b1));
    send_layer(make_layer(12'd4095, 12'd4095, 32'h80FFFFFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_layer(make_layer(12'd4095, 12'd0, 32'hFF000000, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_layer(make_layer(12'd0, 12'd4095, 32'hFFFFFFFF, 8'h80, 1'b1, 1'b1, 1'b1));
    // three-layer run with a hidden middle layer
    send_layer(make_layer(12'd100, 12'd200, 32'h7F102030, 8'hC0, 1'b1, 1'b1, 1'b0));
    send_layer(make_layer(12'd100, 12'd200, 32'hFFFFFFFF, 8'hFF, 1'b0, 1'b0, 1'b0));
    send_layer(make_layer(12'd100, 12'd200, 32'h40FF00FF, 8'hFF, 1'b1, 1'b0, 1'b1));
    // continuation run: blends over the previous pixel
    send_layer(make_layer(12'd3, 12'd9, 32'h80AA5511, 8'h7F, 1'b1, 1'b0, 1'b1));
    wait_all_results();
  endtask

  task automatic test_color_registers();
    write_color(lac_pkg::REG_CHECKER_LIGHT, 32'h00000000);
    write_color(lac_pkg::REG_CHECKER_DARK, 32'hFFFFFFFF);
    // opaque source over the transparent light tile
    send_layer(make_layer(12'd16, 12'd32, 32'hFF5A6B7C, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_layer(make_layer(12'd17, 12'd0, 32'hC0808080, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_layer(make_layer(12'd0, 12'd0, 32'h80000000, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_layer(make_layer(12'd32, 12'd32, 32'hFFFFFFFF, 8'h00, 1'b1, 1'b1, 1'b1));
    wait_all_results();
    write_color(lac_pkg::REG_CHECKER_LIGHT, 32'hFFFFFFFF);
    write_color(lac_pkg::REG_CHECKER_DARK, 32'h00000000);
    send_layer(make_layer(12'd4080, 12'd4095, 32'hFF010203, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_layer(make_layer(12'd4095, 12'd4095, 32'hFF010203, 8'hFE, 1'b1, 1'b1, 1'b1));
    wait_all_results();
    write_color(lac_pkg::REG_CHECKER_LIGHT, lac_pkg::CHECKER_LIGHT_RST);
    write_color(lac_pkg::REG_CHECKER_DARK, lac_pkg::CHECKER_DARK_RST);
  endtask

  task automatic test_random_runs(int unsigned phases, int unsigned layers_per_phase);
    int unsigned budget;
    int unsigned run_len;
    int unsigned burst_left;
    int unsigned gap_max;
    int unsigned k;
    logic [11:0] rx;
    logic [11:0] ry;
    layer_item_t it;
    bit          held;
    for (int p = 0; p < phases; p++) begin
      case (p % 4)
        0: begin gap_max = 0;  rx_stall_max = 0;  rx_run_max = 0;  end
        1: begin gap_max = 6;  rx_stall_max = 4;  rx_run_max = 8;  end
        2: begin gap_max = 20; rx_stall_max = 30; rx_run_max = 3;  end
        default: begin gap_max = 2; rx_stall_max = 2; rx_run_max = 1; end
      endcase
      if (p % 2 == 0) begin
        write_color(lac_pkg::REG_CHECKER_LIGHT, rand_color());
        write_color(lac_pkg::REG_CHECKER_DARK, rand_color());
      end
      budget = layers_per_phase;
      burst_left = $urandom_range(1, 12);
      held = 1'b0;
      while (budget > 0) begin
        run_len = $urandom_range(1, 6);
        rx = rand_coord();
        ry = rand_coord();
        for (k = 0; k < run_len && budget > 0; k++) begin
          it = make_layer(rx, ry, rand_color(), rand_opacity(), $urandom_range(0, 9) != 0,
                          k == 0, k == run_len - 1 || budget == 1);
          // noise: broken runs and stray coordinates
          if ($urandom_range(0, 9) == 0) begin
            it.first = 1'($urandom_range(0, 1));
            it.last  = 1'($urandom_range(0, 1));
            it.x     = rand_coord();
            it.y     = rand_coord();
          end
          if (gap_max != 0) begin
            if (burst_left == 0) begin
              sender_gap($urandom_range(1, gap_max));
              burst_left = $urandom_range(1, 12);
            end
            burst_left--;
          end
          send_layer(it);
          budget--;
        end
        // hold off once per phase until the output side has caught up
        if (!held && budget <= layers_per_phase / 2) begin
          wait_all_results();
          held = 1'b1;
        end
      end
      wait_all_results();
    end
    rx_stall_max = 3;
    rx_run_max = 5;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = lac_pkg::REG_CHECKER_LIGHT;
    cfg_data = '0;
    light_color = lac_pkg::CHECKER_LIGHT_RST;
    dark_color = lac_pkg::CHECKER_DARK_RST;
    accum_pixel = '0;
    error_count = 0;
    layers_sent = 0;
    pixels_checked = 0;
    color_writes = 0;
    rx_hold = 0;
    rx_stall_max = 3;
    rx_run_max = 5;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed_blends();
    test_color_registers();
    test_random_runs(8, 250);

    wait_all_results();
    if (pending_pixels.size() != 0) error_count++;
    $display("Covered %0d layer transfers and %0d composited pixels over %0d color writes,",
             layers_sent, pixels_checked, color_writes);
    $display("including broken runs, hidden and transparent layers, and output stalls.");
    if (error_count == 0) begin
      $display("layer_alpha_compositor_unit test passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("layer_alpha_compositor_unit test failed");
    end
    $finish;
  end

endmodule
